// ===== rtl/sts_pkg.sv =====
package sts_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int SLOT_W     = 4;
  localparam int TIME_W     = 48;
  localparam int IV_W       = 32;
  localparam int ORD_W      = 16;
  localparam int WIN_W      = 16;

  typedef enum logic [2:0] {
    MODE_CREATE  = 3'd0,
    MODE_DELETE  = 3'd1,
    MODE_READ    = 3'd2,
    MODE_WRITE   = 3'd3,
    MODE_ONESHOT = 3'd4,
    MODE_TICK    = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_NOFREE   = 2'd2,
    ST_BADPARAM = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]      mode;
    logic [3:0]      timer_slot;
    logic [IV_W-1:0] interval_ticks;
    logic            periodic;
  } in_word_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [3:0]      result_slot;
    logic [IV_W-1:0] interval_out;
    logic            fired;
    logic            last;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_LIM, S_DUE, S_SEL_INIT, S_SEL, S_FIRE, S_NULL
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_EXEC, CMD_TIME, CMD_LIM, CMD_DUE,
    CMD_SEL_INIT, CMD_SEL, CMD_FIRE, CMD_NULL
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [SLOT_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic due_any;
    logic due_more;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/sorted_timer_scheduler_unit.sv =====
// channel  | valid       | stall        | word
// ---------+-------------+--------------+-------------
// input    | in_valid_i  | in_stall_o   | in_word_i
// output   | out_valid_o | out_stall_i  | out_word_o
// config   | cfg_we_i    | -            | cfg_wdata_i
//
// Non-tick commands: a new word is taken only when idle; its result word is loaded once the output is free.
// Tick: time step, due limit, a due scan over all 16 slots, then for each fired timer a
// slot-by-slot minimum search over the timer store; one null word when nothing fires.
// Reset clears time, arming count and valid bits; no clearing pass is needed.
// A stalled output word holds; the block stops while its result cannot be loaded.
module sorted_timer_scheduler_unit import sts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_word_t         in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_word_t        out_word_o,
  input  logic             cfg_we_i,
  input  logic [WIN_W-1:0] cfg_wdata_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sts_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== rtl/sts_ctrl.sv =====
module sts_ctrl import sts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic              idx_end;

  assign idx_end = (idx_q == {SLOT_W{1'b1}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        if (stat_i.is_tick) state_d = S_LIM;
        else if (stat_i.out_free) state_d = S_IDLE;
      end
      S_LIM:      begin state_d = S_DUE; idx_d = '0; end
      S_DUE: begin
        idx_d = idx_q + 1'b1;
        if (idx_end) state_d = S_SEL_INIT;
      end
      S_SEL_INIT: state_d = stat_i.due_any ? S_SEL : S_NULL;
      S_SEL: begin
        idx_d = idx_q + 1'b1;
        if (idx_end) state_d = S_FIRE;
      end
      S_FIRE: begin
        if (stat_i.out_free) state_d = stat_i.due_more ? S_SEL : S_IDLE;
      end
      S_NULL:     if (stat_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.cmd  = CMD_NONE;
    cmd_o.idx  = idx_q;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE:     if (in_valid_i) cmd_o.cmd = CMD_LOAD;
      S_EXEC: begin
        if (stat_i.is_tick) cmd_o.cmd = CMD_TIME;
        else if (stat_i.out_free) cmd_o.cmd = CMD_EXEC;
      end
      S_LIM:      cmd_o.cmd = CMD_LIM;
      S_DUE:      cmd_o.cmd = CMD_DUE;
      S_SEL_INIT: cmd_o.cmd = CMD_SEL_INIT;
      S_SEL:      cmd_o.cmd = CMD_SEL;
      S_FIRE:     if (stat_i.out_free) cmd_o.cmd = CMD_FIRE;
      S_NULL:     if (stat_i.out_free) cmd_o.cmd = CMD_NULL;
      default:    cmd_o.cmd = CMD_NONE;
    endcase
  end

endmodule

// ===== rtl/sts_dp.sv =====
module sts_dp import sts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  in_word_t         in_word_i,
  input  logic             cfg_we_i,
  input  logic [WIN_W-1:0] cfg_wdata_i,
  input  dp_cmd_t          cmd_i,
  output dp_stat_t         stat_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_word_t        out_word_o
);

  in_word_t          item_q;
  logic [WIN_W-1:0]  win_q;
  logic [TIME_W-1:0] time_q;
  logic [TIME_W-1:0] lim_q;
  logic [ORD_W-1:0]  arm_cnt_q;
  logic [NUM_TIMERS-1:0] valid_q;
  logic [NUM_TIMERS-1:0] due_q;
  logic [TIME_W-1:0] exp_q   [NUM_TIMERS];
  logic [IV_W-1:0]   iv_q    [NUM_TIMERS];
  logic              per_q   [NUM_TIMERS];
  logic [ORD_W-1:0]  ord_q   [NUM_TIMERS];

  logic              have_best_q;
  logic [SLOT_W-1:0] best_q;
  logic [TIME_W-1:0] best_exp_q;
  logic [ORD_W-1:0]  best_ord_q;

  logic              out_valid_q;
  out_word_t         out_q;

  logic              any_free;
  logic [SLOT_W-1:0] free_idx;
  logic [TIME_W:0]   lim_sum;
  logic              better;
  logic [NUM_TIMERS-1:0] best_oh;
  logic              emit;
  out_word_t         res;
  logic [SLOT_W-1:0] sl;
  logic [SLOT_W-1:0] ix;

  assign sl = item_q.timer_slot;
  assign ix = cmd_i.idx;

  // lowest free slot
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        any_free = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign lim_sum = {1'b0, time_q} + {{(TIME_W + 1 - WIN_W){1'b0}}, win_q};
  assign better  = !have_best_q || (exp_q[ix] < best_exp_q) ||
                   ((exp_q[ix] == best_exp_q) && (ord_q[ix] < best_ord_q));
  assign best_oh = NUM_TIMERS'(1) << best_q;

  assign stat_o.is_tick  = (item_q.mode == MODE_TICK);
  assign stat_o.due_any  = |due_q;
  assign stat_o.due_more = |(due_q & ~best_oh);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  // result word of the current command
  always_comb begin
    res  = '0;
    emit = 1'b0;
    res.last = 1'b1;
    case (cmd_i.cmd)
      CMD_EXEC: begin
        emit = 1'b1;
        case (item_q.mode)
          MODE_CREATE: begin
            if (item_q.interval_ticks == '0) res.status = ST_BADPARAM;
            else if (!any_free) res.status = ST_NOFREE;
            else res.result_slot = free_idx;
          end
          MODE_DELETE, MODE_WRITE, MODE_ONESHOT: begin
            if (!valid_q[sl]) res.status = ST_NOTFOUND;
          end
          MODE_READ: begin
            if (!valid_q[sl]) res.status = ST_NOTFOUND;
            else res.interval_out = iv_q[sl];
          end
          default: res.status = ST_BADPARAM;
        endcase
      end
      CMD_FIRE: begin
        emit = 1'b1;
        res.result_slot = best_q;
        res.fired = 1'b1;
        res.last = !stat_o.due_more;
      end
      CMD_NULL: emit = 1'b1;
      default:  emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      time_q      <= '0;
      arm_cnt_q   <= '0;
      valid_q     <= '0;
      due_q       <= '0;
      have_best_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) win_q <= cfg_wdata_i;
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (cmd_i.cmd)
        CMD_EXEC: begin
          case (item_q.mode)
            MODE_CREATE: begin
              if (item_q.interval_ticks != '0 && any_free) begin
                valid_q[free_idx] <= 1'b1;
                arm_cnt_q         <= arm_cnt_q + 1'b1;
              end
            end
            MODE_DELETE: if (valid_q[sl]) valid_q[sl] <= 1'b0;
            default: ;
          endcase
        end
        CMD_TIME: time_q <= time_q + 1'b1;
        CMD_DUE:  due_q[ix] <= valid_q[ix] && (exp_q[ix] <= lim_q);
        CMD_SEL_INIT: have_best_q <= 1'b0;
        CMD_SEL: if (due_q[ix] && better) have_best_q <= 1'b1;
        CMD_FIRE: begin
          due_q[best_q] <= 1'b0;
          have_best_q   <= 1'b0;
          if (per_q[best_q]) arm_cnt_q <= arm_cnt_q + 1'b1;
          else valid_q[best_q] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers and timer store
  always_ff @(posedge clk_i) begin
    if (emit) out_q <= res;
    case (cmd_i.cmd)
      CMD_LOAD: item_q <= in_word_i;
      CMD_EXEC: begin
        case (item_q.mode)
          MODE_CREATE: begin
            if (item_q.interval_ticks != '0 && any_free) begin
              iv_q[free_idx]  <= item_q.interval_ticks;
              per_q[free_idx] <= item_q.periodic;
              exp_q[free_idx] <= time_q + {{(TIME_W - IV_W){1'b0}}, item_q.interval_ticks};
              ord_q[free_idx] <= arm_cnt_q;
            end
          end
          MODE_WRITE:   if (valid_q[sl]) iv_q[sl] <= item_q.interval_ticks;
          MODE_ONESHOT: if (valid_q[sl]) per_q[sl] <= 1'b0;
          default: ;
        endcase
      end
      // saturate the due limit at the top of the time range
      CMD_LIM: lim_q <= lim_sum[TIME_W] ? {TIME_W{1'b1}} : lim_sum[TIME_W-1:0];
      CMD_SEL: begin
        if (due_q[ix] && better) begin
          best_q     <= ix;
          best_exp_q <= exp_q[ix];
          best_ord_q <= ord_q[ix];
        end
      end
      CMD_FIRE: begin
        if (per_q[best_q]) begin
          exp_q[best_q] <= time_q + {{(TIME_W - IV_W){1'b0}}, iv_q[best_q]};
          ord_q[best_q] <= arm_cnt_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== tb/sv/sorted_timer_scheduler_unit_test.sv =====
`timescale 1ns / 100ps

module sorted_timer_scheduler_unit_test;
  import sts_pkg::*;

  localparam logic [2:0] MODE_UNDEF_LO = 3'd6;
  localparam logic [2:0] MODE_UNDEF_HI = 3'd7;
  localparam int         CYCLE_LIMIT   = 1000000;
  localparam int         HOLD_CYCLES   = 350;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_word_t         in_word_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_word_t        out_word_o;
  logic             cfg_we_i    = 1'b0;
  logic [WIN_W-1:0] cfg_wdata_i = '0;

  sorted_timer_scheduler_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // timer bank mirror
  logic [WIN_W-1:0]  win_mdl;
  logic [TIME_W-1:0] now_mdl;
  logic [ORD_W-1:0]  arm_cnt_mdl;
  logic              live_mdl   [NUM_TIMERS];
  logic [TIME_W-1:0] expiry_mdl [NUM_TIMERS];
  logic [IV_W-1:0]   reload_mdl [NUM_TIMERS];
  logic              periodic_mdl [NUM_TIMERS];
  logic [ORD_W-1:0]  order_mdl  [NUM_TIMERS];

  in_word_t  pending_q [$];
  out_word_t due_words_q [$];

  int  mismatches = 0;
  int  accepted = 0;
  int  received = 0;
  int  fires_seen = 0;
  int  ticks_sent = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_used = 1'b0;
  int  hold_left = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void push_word(status_e st, logic [3:0] sl, logic [IV_W-1:0] iv,
                                    logic fi, logic la);
    out_word_t w;
    w.status       = st;
    w.result_slot  = sl;
    w.interval_out = iv;
    w.fired        = fi;
    w.last         = la;
    due_words_q.push_back(w);
  endfunction

  function automatic void rearm(int s);
    expiry_mdl[s] = now_mdl + TIME_W'(reload_mdl[s]);
    order_mdl[s]  = arm_cnt_mdl;
    arm_cnt_mdl   = arm_cnt_mdl + 1'b1;
  endfunction

  function automatic bit fires_first(int a, int b);
    if (expiry_mdl[a] != expiry_mdl[b]) return expiry_mdl[a] < expiry_mdl[b];
    if (order_mdl[a] != order_mdl[b]) return order_mdl[a] < order_mdl[b];
    return a < b;
  endfunction

  function automatic void predict_timers(in_word_t w);
    int s;
    int n;
    int j;
    int due [NUM_TIMERS];
    logic [TIME_W:0] lim;
    s = int'(w.timer_slot);
    case (w.mode)
      MODE_CREATE: begin
        if (w.interval_ticks == '0) begin
          push_word(ST_BADPARAM, '0, '0, 1'b0, 1'b1);
        end else begin
          s = NUM_TIMERS;
          for (int i = NUM_TIMERS - 1; i >= 0; i--) if (!live_mdl[i]) s = i;
          if (s == NUM_TIMERS) begin
            push_word(ST_NOFREE, '0, '0, 1'b0, 1'b1);
          end else begin
            live_mdl[s]     = 1'b1;
            reload_mdl[s]   = w.interval_ticks;
            periodic_mdl[s] = w.periodic;
            rearm(s);
            push_word(ST_OK, 4'(s), '0, 1'b0, 1'b1);
          end
        end
      end
      MODE_DELETE, MODE_READ, MODE_WRITE, MODE_ONESHOT: begin
        if (!live_mdl[s]) begin
          push_word(ST_NOTFOUND, '0, '0, 1'b0, 1'b1);
        end else begin
          case (w.mode)
            MODE_DELETE: begin
              live_mdl[s] = 1'b0;
              push_word(ST_OK, '0, '0, 1'b0, 1'b1);
            end
            MODE_READ: push_word(ST_OK, '0, reload_mdl[s], 1'b0, 1'b1);
            MODE_WRITE: begin
              reload_mdl[s] = w.interval_ticks;
              push_word(ST_OK, '0, '0, 1'b0, 1'b1);
            end
            default: begin
              periodic_mdl[s] = 1'b0;
              push_word(ST_OK, '0, '0, 1'b0, 1'b1);
            end
          endcase
        end
      end
      MODE_TICK: begin
        now_mdl = now_mdl + 1'b1;
        lim = {1'b0, now_mdl} + (TIME_W + 1)'(win_mdl);
        if (lim[TIME_W]) lim = {1'b0, {TIME_W{1'b1}}};
        n = 0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (live_mdl[i] && {1'b0, expiry_mdl[i]} <= lim) begin
            j = n;
            n++;
            while (j > 0 && fires_first(i, due[j-1])) begin
              due[j] = due[j-1];
              j--;
            end
            due[j] = i;
          end
        end
        if (n == 0) push_word(ST_OK, '0, '0, 1'b0, 1'b1);
        for (int k = 0; k < n; k++) begin
          if (periodic_mdl[due[k]]) rearm(due[k]);
          else live_mdl[due[k]] = 1'b0;
          push_word(ST_OK, 4'(due[k]), '0, 1'b1, k == n - 1);
        end
      end
      default: push_word(ST_BADPARAM, '0, '0, 1'b0, 1'b1);
    endcase
  endfunction

  // sender
  always @(posedge clk_i) begin
    bit       take;
    bit       nxt_valid;
    in_word_t nxt_word;
    if (rst_ni) begin
      take = in_valid_i && !in_stall_o;
      if (take) begin
        predict_timers(in_word_i);
        accepted++;
        if (in_word_i.mode == MODE_TICK) ticks_sent++;
      end
      nxt_valid = in_valid_i;
      nxt_word  = in_word_i;
      if (!in_valid_i || take) begin
        nxt_valid = 1'b0;
        if (pending_q.size() != 0 && (no_idle || $urandom_range(99) >= 23)) begin
          nxt_valid = 1'b1;
          nxt_word  = pending_q.pop_front();
        end
      end
      in_valid_i <= nxt_valid;
      in_word_i  <= nxt_word;
    end
  end

  // long output hold-off, counted down here
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_req && !hold_used) begin
        hold_used <= 1'b1;
        hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        received++;
        if (out_word_o.fired) fires_seen++;
        if (due_words_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %p", out_word_o);
        end else begin
          exp_w = due_words_q.pop_front();
          if (exp_w.status !== out_word_o.status ||
              exp_w.result_slot !== out_word_o.result_slot ||
              exp_w.interval_out !== out_word_o.interval_out ||
              exp_w.fired !== out_word_o.fired ||
              exp_w.last !== out_word_o.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", exp_w, out_word_o);
          end
        end
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !no_idle && ($urandom_range(99) < 23);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic in_word_t mk_word(logic [2:0] md, logic [3:0] sl, logic [IV_W-1:0] iv,
                                       logic per);
    in_word_t w;
    w.mode           = md;
    w.timer_slot     = sl;
    w.interval_ticks = iv;
    w.periodic       = per;
    return w;
  endfunction

  function automatic in_word_t random_word();
    int               pick;
    int               ivsel;
    logic [IV_W-1:0]  iv;
    logic [2:0]       md;
    pick  = $urandom_range(99);
    ivsel = $urandom_range(99);
    if (ivsel < 55) iv = IV_W'($urandom_range(8, 1));
    else if (ivsel < 80) iv = IV_W'($urandom_range(200, 9));
    else if (ivsel < 93) iv = $urandom;
    else iv = '0;
    if (pick < 40) md = MODE_TICK;
    else if (pick < 65) md = MODE_CREATE;
    else if (pick < 73) md = MODE_DELETE;
    else if (pick < 81) md = MODE_READ;
    else if (pick < 89) md = MODE_WRITE;
    else if (pick < 95) md = MODE_ONESHOT;
    else if (pick < 98) md = MODE_UNDEF_LO;
    else md = MODE_UNDEF_HI;
    return mk_word(md, 4'($urandom_range(15)), iv, 1'($urandom_range(1)));
  endfunction

  task automatic settle();
    wait (pending_q.size() == 0 && !in_valid_i && due_words_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_window(logic [WIN_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_mdl = v;
  endtask

  task automatic queue_random(int n);
    repeat (n) pending_q.push_back(random_word());
  endtask

  initial begin
    win_mdl     = '0;
    now_mdl     = '0;
    arm_cnt_mdl = '0;
    for (int i = 0; i < NUM_TIMERS; i++) live_mdl[i] = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_window('0);

    // directed: bad create, extremes, each mode, unknown codes
    pending_q.push_back(mk_word(MODE_CREATE, 4'd0, '0, 1'b1));
    pending_q.push_back(mk_word(MODE_CREATE, 4'd15, '1, 1'b1));
    pending_q.push_back(mk_word(MODE_CREATE, 4'd0, 32'd1, 1'b0));
    pending_q.push_back(mk_word(MODE_CREATE, 4'd0, 32'd2, 1'b1));
    pending_q.push_back(mk_word(MODE_CREATE, 4'd0, 32'd2, 1'b1));
    pending_q.push_back(mk_word(MODE_READ, 4'd0, '0, 1'b0));
    pending_q.push_back(mk_word(MODE_READ, 4'd9, '0, 1'b0));
    pending_q.push_back(mk_word(MODE_DELETE, 4'd15, '1, 1'b1));
    pending_q.push_back(mk_word(MODE_WRITE, 4'd2, '0, 1'b0));
    pending_q.push_back(mk_word(MODE_ONESHOT, 4'd12, '0, 1'b0));
    pending_q.push_back(mk_word(MODE_UNDEF_LO, 4'd3, '1, 1'b1));
    pending_q.push_back(mk_word(MODE_UNDEF_HI, 4'd0, '0, 1'b0));
    repeat (4) pending_q.push_back(mk_word(MODE_TICK, 4'd0, '0, 1'b0));
    pending_q.push_back(mk_word(MODE_ONESHOT, 4'd3, '0, 1'b0));
    pending_q.push_back(mk_word(MODE_WRITE, 4'd0, 32'd5, 1'b0));
    pending_q.push_back(mk_word(MODE_READ, 4'd0, '0, 1'b0));
    repeat (3) pending_q.push_back(mk_word(MODE_TICK, 4'd0, '0, 1'b0));
    pending_q.push_back(mk_word(MODE_DELETE, 4'd0, '0, 1'b0));
    pending_q.push_back(mk_word(MODE_READ, 4'd0, '0, 1'b0));
    settle();

    // fill the bank past its size so the no-free case shows up
    repeat (18) pending_q.push_back(mk_word(MODE_CREATE, 4'd0, 32'd40, 1'b1));
    queue_random(50);
    settle();

    set_window(16'hffff);
    hold_req = 1'b1;
    queue_random(80);
    settle();

    set_window(16'd3);
    no_idle = 1'b1;
    queue_random(80);
    settle();
    no_idle = 1'b0;

    set_window(16'($urandom_range(20)));
    queue_random(90);
    settle();

    repeat (50) @(posedge clk_i);
    $display("run: %0d words in (%0d ticks), %0d words out, %0d expiries, %0d cycles",
             accepted, ticks_sent, received, fires_seen, cycles);
    $display("fire windows 0, max, 3 and random; one long output hold-off");
    if (mismatches == 0 && due_words_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d words still expected", mismatches, due_words_q.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
